>>> rtl/core/ohtab_pkg.sv
// ----------------------------------------------------------------------------
// ohtab_pkg
// shared types and constants of the open addressing hash table
// ----------------------------------------------------------------------------
package ohtab_pkg;

   localparam logic [1:0] CMD_GET = 2'd0;
   localparam logic [1:0] CMD_PUT = 2'd1;
   localparam logic [1:0] CMD_DEL = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_LIVE  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam int HOME_BITS = 16;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key_bytes;
      logic [3:0]  key_length;
      logic [31:0] put_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] get_value;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [63:0]          key_bytes;
      logic [3:0]           key_length;
      logic [31:0]          put_value;
      logic [HOME_BITS-1:0] home;
   } entry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_HASH,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_EVAL,
      B_DONE
   } back_state_type;

   // fnv prime is 2^40 + 0x1b3
   function automatic logic [63:0] fnv_mul(input logic [63:0] h);
      fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
   endfunction

endpackage

>>> rtl/core/ohtab_ram.sv
// ----------------------------------------------------------------------------
// ohtab_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ohtab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ohtab_front.sv
// ----------------------------------------------------------------------------
// ohtab_front
// accepts requests, hashes the key with fnv-1 and reduces it to a home slot
// ----------------------------------------------------------------------------
module ohtab_front #(
   parameter int SLOTS     = 1024,
   parameter int KEY_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clearing,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ohtab_pkg::req_type   req_payload,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ohtab_pkg::entry_type push_entry
);
   import ohtab_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int VW = AW + 8;
   localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

   front_state_type state_ff, state_in;
   logic [1:0]     cmd_ff;
   logic [63:0]    key_ff;
   logic [3:0]     len_ff;
   logic [31:0]    val_ff;
   logic [63:0]    h_ff, h_in;
   logic [3:0]     cnt_ff;
   logic [3:0]     step_ff;
   logic [7:0]     q_ff;
   logic [AW-1:0]  r_ff;
   logic [VW-1:0]  v_cur;
   logic [VW+31:0] prod;
   logic [7:0]     q_in;
   logic [VW-1:0]  rem;
   logic [VW-1:0]  r_in;
   logic [3:0]     len_c;
   logic [63:0]    key_m;
   logic           accept;
   logic [AW-1:0]  home;

   assign accept = req_valid && req_ready;
   assign len_c = (req_payload.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                           : req_payload.key_length;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         key_m[b*8 +: 8] = (4'(b) < len_c) ? req_payload.key_bytes[b*8 +: 8] : 8'h00;
      end
   end

   // remainder one hash byte at a time, quotient estimate by reciprocal
   assign h_in  = fnv_mul(h_ff) ^ {56'h0, key_ff[{cnt_ff[2:0], 3'b000} +: 8]};
   assign v_cur = {r_ff, h_ff[63:56]};
   assign prod  = (VW+32)'(v_cur) * (VW+32)'(RECIP);
   assign q_in  = prod[39:32];
   assign rem   = v_cur - VW'(q_ff) * VW'(SLOTS);
   assign r_in  = (rem >= VW'(SLOTS)) ? rem - VW'(SLOTS) : rem;
   assign home  = POW2 ? h_ff[AW-1:0] : r_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_HASH;
         end
         F_HASH: begin
            if (cnt_ff == len_ff) state_in = POW2 ? F_PUSH : F_MOD;
         end
         F_MOD: begin
            if (step_ff == 4'd15) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == F_IDLE) && !clearing;
      push_valid = (state_ff == F_PUSH);
      push_entry.command    = cmd_ff;
      push_entry.key_bytes  = key_ff;
      push_entry.key_length = len_ff;
      push_entry.put_value  = val_ff;
      push_entry.home       = HOME_BITS'(home);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         cmd_ff <= req_payload.command;
         key_ff <= key_m;
         len_ff <= len_c;
         val_ff <= req_payload.put_value;
         h_ff   <= FNV_BASIS;
         cnt_ff <= 4'd0;
      end else if (state_ff == F_HASH) begin
         if (cnt_ff != len_ff) begin
            h_ff   <= h_in;
            cnt_ff <= cnt_ff + 4'd1;
         end else begin
            r_ff    <= '0;
            step_ff <= 4'd0;
         end
      end else if (state_ff == F_MOD) begin
         step_ff <= step_ff + 4'd1;
         if (!step_ff[0]) begin
            q_ff <= q_in;
         end else begin
            r_ff <= r_in[AW-1:0];
            h_ff <= {h_ff[55:0], 8'h00};
         end
      end
   end

endmodule

>>> rtl/core/ohtab_queue.sv
// ----------------------------------------------------------------------------
// ohtab_queue
// two entry queue between the hashing front and the probing back
// ----------------------------------------------------------------------------
module ohtab_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ohtab_pkg::entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ohtab_pkg::entry_type pop_entry
);
   import ohtab_pkg::*;

   entry_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> rtl/core/ohtab_back.sv
// ----------------------------------------------------------------------------
// ohtab_back
// clears the slot marks after reset, then probes slots linearly per request
// ----------------------------------------------------------------------------
module ohtab_back #(
   parameter int SLOTS      = 1024,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clearing,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ohtab_pkg::entry_type pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ohtab_pkg::rsp_type   rsp_payload
);
   import ohtab_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int KW = KEY_BYTES * 8;
   localparam int DW = KW + 4 + VALUE_BITS;

   back_state_type state_ff, state_in;
   logic [AW-1:0]         clr_ff;
   logic [AW-1:0]         slot_ff;
   logic [AW-1:0]         cnt_ff;
   logic [1:0]            cmd_ff;
   logic [KW-1:0]         key_ff;
   logic [3:0]            len_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic                  found_ff;
   logic [31:0]           getv_ff;
   logic [1:0]            status_ff;
   logic [AW:0]           filled_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [1:0]            mark_q;
   logic [DW-1:0]         data_q;
   logic [KW-1:0]         q_key;
   logic [3:0]            q_len;
   logic [VALUE_BITS-1:0] q_val;
   logic [63:0]           q_val64;
   logic [63:0]           in_val64;
   logic                  mark_we;
   logic [AW-1:0]         mark_wa;
   logic [1:0]            mark_wd;
   logic                  data_we;
   logic                  hit;
   logic                  last;
   logic                  stop;
   logic                  fill_inc;
   logic                  e_found;
   logic [1:0]            e_status;
   logic [31:0]           e_getv;
   logic                  out_free;

   assign q_key   = data_q[DW-1 -: KW];
   assign q_len   = data_q[VALUE_BITS+3 -: 4];
   assign q_val   = data_q[VALUE_BITS-1:0];
   assign q_val64 = 64'(q_val);
   assign in_val64 = 64'(pop_entry.put_value);
   assign hit  = (mark_q == MARK_LIVE) && (q_len == len_ff) && (q_key == key_ff);
   assign last = (cnt_ff == AW'(SLOTS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   ohtab_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (slot_ff),
      .rd_data (mark_q)
   );

   ohtab_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (slot_ff),
      .wr_data ({key_ff, len_ff, val_ff}),
      .rd_addr (slot_ff),
      .rd_data (data_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: begin
            if (clr_ff == AW'(SLOTS - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (pop_valid) state_in = B_READ;
         end
         B_READ: state_in = B_EVAL;
         B_EVAL: begin
            state_in = stop ? B_DONE : B_READ;
         end
         B_DONE: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_CLEAR;
      endcase
   end

   always_comb begin
      clearing = (state_ff == B_CLEAR);
      pop_ready = (state_ff == B_IDLE);
      mark_we  = 1'b0;
      mark_wa  = slot_ff;
      mark_wd  = MARK_EMPTY;
      data_we  = 1'b0;
      stop     = 1'b0;
      fill_inc = 1'b0;
      e_found  = 1'b0;
      e_status = ST_MISS;
      e_getv   = 32'h0;
      unique case (state_ff)
         B_CLEAR: begin
            mark_we = 1'b1;
            mark_wa = clr_ff;
         end
         B_EVAL: begin
            if (cmd_ff == CMD_PUT) begin
               if (hit) begin
                  stop     = 1'b1;
                  e_found  = 1'b1;
                  e_status = ST_OK;
                  data_we  = 1'b1;
               end else if (mark_q != MARK_LIVE) begin
                  stop     = 1'b1;
                  e_status = ST_OK;
                  mark_we  = 1'b1;
                  mark_wd  = MARK_LIVE;
                  data_we  = 1'b1;
                  fill_inc = (mark_q == MARK_EMPTY);
               end else if (last) begin
                  stop     = 1'b1;
                  e_status = ST_FULL;
               end
            end else begin
               if (hit) begin
                  stop     = 1'b1;
                  e_found  = 1'b1;
                  e_status = ST_OK;
                  if (cmd_ff == CMD_DEL) begin
                     mark_we = 1'b1;
                     mark_wd = MARK_TOMB;
                  end else begin
                     e_getv = q_val64[31:0];
                  end
               end else if (mark_q == MARK_EMPTY || last) begin
                  stop = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (fill_inc) filled_ff <= filled_ff + (AW+1)'(1);
         if (state_ff == B_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == B_IDLE && pop_valid) begin
         cmd_ff  <= pop_entry.command;
         key_ff  <= pop_entry.key_bytes[KW-1:0];
         len_ff  <= pop_entry.key_length;
         val_ff  <= in_val64[VALUE_BITS-1:0];
         slot_ff <= pop_entry.home[AW-1:0];
         cnt_ff  <= '0;
      end else if (state_ff == B_EVAL) begin
         if (stop) begin
            found_ff  <= e_found;
            getv_ff   <= e_getv;
            status_ff <= e_status;
         end else begin
            slot_ff <= (slot_ff == AW'(SLOTS - 1)) ? '0 : slot_ff + AW'(1);
            cnt_ff  <= cnt_ff + AW'(1);
         end
      end
      if (state_ff == B_DONE && out_free) begin
         rsp_ff.found     <= found_ff;
         rsp_ff.get_value <= getv_ff;
         rsp_ff.status    <= status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= (AW+1)'(SLOTS))
      else $error("filled count above slot count");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop_ready)
      else $error("request taken during clearing pass");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_READ) |=> (state_ff == B_EVAL))
      else $error("probe read not followed by evaluation");

endmodule

>>> rtl/core/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// linear probing key/value table with fnv-1 hashing
// ----------------------------------------------------------------------------
// requests (lookup, insert or update, delete) enter on the req_ valid/ready
// channel; each gives one word on the rsp_ channel with found, value, status.
// the front hashes one key byte per cycle; when SLOTS is not a power of two
// a reduction gives the home slot, with a quotient estimate and a remainder
// step for each hash byte. a two word queue parts the front from the back,
// which probes the slot memories one slot at a time, in a read state and an
// evaluate state per slot. the front takes a new request only after it has
// pushed the last one into the queue; the back takes the next one from the
// queue only after its result has gone to the output register.
// after reset the back runs a clearing pass that sets every slot mark empty;
// req_ready stays low until it ends.
// results wait in an output register; while rsp_ready is low the front
// keeps hashing and filling the queue, and the back holds its finished word.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
   parameter int SLOTS      = 1024,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ohtab_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ohtab_pkg::rsp_type rsp_payload
);
   import ohtab_pkg::*;

   logic      clearing;
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   ohtab_front #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .clearing    (clearing),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   ohtab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   ohtab_back #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .clearing    (clearing),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/sv/tb_open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_table
// self-checking bench for the linear probing fnv-1 key/value table
// ----------------------------------------------------------------------------
// a directed table of requests runs first, with results typed in where they
// are plain, then random lookups, inserts and deletes over a small key pool
// so that hits, tombstones and reuse are frequent. a shadow table predicts
// every response word, and the words are compared in order. both channels
// idle at random, and once the receiver holds off long enough to stall input.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_table;
   import ohtab_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = 1024;
   localparam int RANDOM_WORDS = 1950;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   open_addressing_hash_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   typedef struct {
      req_type word;
      logic    typed;
      rsp_type want;
   } step_type;

   logic [1:0]  shadow_mark [TABLE_SLOTS];
   logic [63:0] shadow_key [TABLE_SLOTS];
   logic [3:0]  shadow_len [TABLE_SLOTS];
   logic [31:0] shadow_value [TABLE_SLOTS];

   rsp_type pending_rsp[$];
   step_type steps[$];
   logic [63:0] key_pool[16];
   int mismatches = 0;
   logic sending_done = 0;
   logic hold_done = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [63:0] fnv1_hash(input logic [63:0] k, input int n);
      logic [63:0] h;
      h = 64'hCBF29CE484222325;
      for (int i = 0; i < n; i++) begin
         h = h * 64'h100000001B3;
         h = h ^ {56'd0, k[8*i +: 8]};
      end
      return h;
   endfunction

   function automatic rsp_type table_access(input req_type r);
      rsp_type o;
      int n;
      logic [63:0] k;
      int home;
      int s;
      n = (r.key_length > 8) ? 8 : int'(r.key_length);
      k = (n == 8) ? r.key_bytes : (r.key_bytes & ((64'd1 << (8 * n)) - 1));
      home = int'(fnv1_hash(k, n) % TABLE_SLOTS);
      o = '0;
      o.status = (r.command == CMD_PUT) ? ST_FULL : ST_MISS;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         s = (home + i) % TABLE_SLOTS;
         if (shadow_mark[s] == MARK_LIVE && shadow_len[s] == n && shadow_key[s] == k) begin
            o.found = 1;
            o.status = ST_OK;
            if (r.command == CMD_PUT) shadow_value[s] = r.put_value;
            else if (r.command == CMD_DEL) shadow_mark[s] = MARK_TOMB;
            else o.get_value = shadow_value[s];
            break;
         end
         if (r.command == CMD_PUT && shadow_mark[s] != MARK_LIVE) begin
            shadow_mark[s] = MARK_LIVE;
            shadow_key[s] = k;
            shadow_len[s] = 4'(n);
            shadow_value[s] = r.put_value;
            o.status = ST_OK;
            break;
         end
         if (r.command != CMD_PUT && shadow_mark[s] == MARK_EMPTY) break;
      end
      return o;
   endfunction

   function automatic step_type make_step(input logic [1:0] c, input logic [63:0] k,
                                          input logic [3:0] n, input logic [31:0] v,
                                          input logic t, input rsp_type w);
      step_type st;
      st.word.command = c;
      st.word.key_bytes = k;
      st.word.key_length = n;
      st.word.put_value = v;
      st.typed = t;
      st.want = w;
      return st;
   endfunction

   task automatic gap(input int odds);
      int n;
      n = 0;
      if ($urandom_range(99) < odds)
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      if (n > 0) req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_word(input step_type st);
      rsp_type p;
      req_valid <= 1;
      req_payload <= st.word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = table_access(st.word);
      if (st.typed && p != st.want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row disagrees: typed %h predicted %h", st.want, p);
      end
      pending_rsp.push_back(p);
   endtask

   initial begin
      req_type r;
      int phase;
      for (int i = 0; i < TABLE_SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      reset <= 1;
      req_valid <= 0;
      req_payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 0;

      steps.push_back(make_step(CMD_GET, 64'h0, 4'd0, 32'h0, 1, '{0, 32'h0, ST_MISS}));
      steps.push_back(make_step(CMD_DEL, 64'hFFFFFFFFFFFFFFFF, 4'd8, 32'h0, 1,
                                '{0, 32'h0, ST_MISS}));
      steps.push_back(make_step(CMD_PUT, 64'h0, 4'd0, 32'hFFFFFFFF, 1, '{0, 32'h0, ST_OK}));
      steps.push_back(make_step(CMD_GET, 64'hFFFF, 4'd0, 32'h0, 1,
                                '{1, 32'hFFFFFFFF, ST_OK}));
      steps.push_back(make_step(CMD_PUT, 64'hFFFFFFFFFFFFFFFF, 4'd15, 32'h0, 1,
                                '{0, 32'h0, ST_OK}));
      steps.push_back(make_step(CMD_GET, 64'hFFFFFFFFFFFFFFFF, 4'd8, 32'h0, 1,
                                '{1, 32'h0, ST_OK}));
      steps.push_back(make_step(CMD_PUT, 64'hFFFFFFFFFFFFFFFF, 4'd9, 32'h12345678, 1,
                                '{1, 32'h0, ST_OK}));
      steps.push_back(make_step(2'd3, 64'hFFFFFFFFFFFFFFFF, 4'd8, 32'h0, 1,
                                '{1, 32'h12345678, ST_OK}));
      steps.push_back(make_step(CMD_PUT, 64'hAA55, 4'd1, 32'h1, 0, '0));
      steps.push_back(make_step(CMD_GET, 64'h55, 4'd1, 32'h0, 0, '0));
      steps.push_back(make_step(CMD_GET, 64'h55, 4'd2, 32'h0, 0, '0));
      steps.push_back(make_step(CMD_DEL, 64'hFF55, 4'd1, 32'h0, 1, '{1, 32'h0, ST_OK}));
      steps.push_back(make_step(CMD_GET, 64'h55, 4'd1, 32'h0, 1, '{0, 32'h0, ST_MISS}));
      steps.push_back(make_step(CMD_DEL, 64'h55, 4'd1, 32'h0, 1, '{0, 32'h0, ST_MISS}));
      steps.push_back(make_step(CMD_PUT, 64'h55, 4'd1, 32'h2, 1, '{0, 32'h0, ST_OK}));
      steps.push_back(make_step(CMD_PUT, 64'h0102030405060708, 4'd4, 32'hA5A5A5A5, 0, '0));
      steps.push_back(make_step(CMD_GET, 64'hFFFFFFFF05060708, 4'd4, 32'h0, 0, '0));
      foreach (steps[i]) begin
         send_word(steps[i]);
         gap(30);
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         phase = $urandom_range(99);
         r.command = (phase < 3) ? 2'd3 : 2'($urandom_range(2));
         if (phase < 80) begin
            r.key_bytes = key_pool[$urandom_range(15)] ^ ({$urandom, $urandom} & ~64'hFFFF);
            r.key_length = 4'($urandom_range(2, 1));
         end else begin
            r.key_bytes = {$urandom, $urandom};
            r.key_length = 4'($urandom_range(15));
         end
         r.put_value = $urandom;
         send_word(make_step(r.command, r.key_bytes, r.key_length, r.put_value, 0, '0));
         if (i % 200 < 150) gap(25);
      end
      req_valid <= 0;
      sending_done = 1;
   end

   initial begin
      rsp_type w;
      int hold;
      int served;
      rsp_ready <= 0;
      served = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            served++;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response word with none pending: %h", rsp_payload);
            end else begin
               w = pending_rsp.pop_front();
               if (rsp_payload.found !== w.found || rsp_payload.get_value !== w.get_value ||
                   rsp_payload.status !== w.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected %h actual %h", w, rsp_payload);
               end
            end
         end
         if (served == 300 && !hold_done) begin
            hold_done = 1;
            rsp_ready <= 0;
            hold = 0;
            while (hold < 400) begin
               @(posedge clock);
               hold++;
            end
            rsp_ready <= 1;
         end else if ((served / 250) % 2 == 1) begin
            rsp_ready <= 1;
         end else begin
            rsp_ready <= ($urandom_range(99) < 70);
         end
      end
   end

   initial begin
      int waited;
      @(negedge reset);
      wait (sending_done);
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2200) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
